FILE: hdl/ftla_pkg.sv
// ----------------------------------------------------------------------------
// ftla_pkg
// Shared types and constants for the fresh-then-LRU identifier allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ftla_pkg;

  localparam int unsigned ID_W        = 16;
  localparam int unsigned FRESH_W     = ID_W + 1;
  localparam int unsigned DEPTH_DEF   = 1024;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_ADDR_W  = 3;

  localparam logic [ID_W-1:0] RANGE_LOW_RST  = 16'd1024;
  localparam logic [ID_W-1:0] RANGE_HIGH_RST = 16'd2047;

  localparam logic REG_RANGE_LOW  = 1'b0;
  localparam logic REG_RANGE_HIGH = 1'b1;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_FRESH   = 3'd0,
    ST_REUSE   = 3'd1,
    ST_NONE    = 3'd2,
    ST_STORED  = 3'd3,
    ST_DROPPED = 3'd4
  } status_t;

  typedef struct packed {
    logic exec;
    logic load;
  } ftla_cmd_t;

  typedef struct packed {
    logic reuse;
  } ftla_sts_t;

endpackage

`default_nettype wire

FILE: hdl/ftla_ctrl.sv
// ----------------------------------------------------------------------------
// ftla_ctrl
// Handshake controller: accepts commands, waits for the ring read on a
// reused grant, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ftla_ctrl
  import ftla_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire ftla_sts_t sts,
  output ftla_cmd_t      cmd
);

  typedef enum logic {
    S_IDLE,
    S_FETCH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign cmd.exec  = accept;
  assign cmd.load  = (state_r == S_FETCH);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (sts.reuse) begin
            state_nxt = S_FETCH;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_FETCH: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ftla_dp.sv
// ----------------------------------------------------------------------------
// ftla_dp
// Datapath: range registers, fresh counter, recycle ring memory with its
// pointers and fill count, and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ftla_dp
  import ftla_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ftla_cmd_t             cmd,
  output ftla_sts_t                  sts,
  input  wire logic                  in_command,
  input  wire logic [ID_W-1:0]       in_ident_in,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic [ID_W-1:0]            out_ident_out,
  output logic [2:0]                 out_status
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = AW + 1;
  localparam logic [FRESH_W-1:0] DEPTH_F = FRESH_W'(DEPTH);

  logic [ID_W-1:0]    range_low_r, range_high_r;
  logic [FRESH_W-1:0] next_fresh_r;
  logic [AW-1:0]      head_r, tail_r;
  logic [CW-1:0]      fill_r;
  logic [ID_W-1:0]    ring_mem [DEPTH];
  logic [ID_W-1:0]    rd_data_r;
  logic [ID_W-1:0]    out_ident_r;
  status_t            out_status_r;

  logic [FRESH_W-1:0] span, cap_f;
  logic [CW-1:0]      cap;
  logic               range_empty, fresh_ok, ring_has, ring_room;
  logic [PW-1:0]      head_inc, tail_inc;
  logic [AW-1:0]      head_wrap, tail_wrap;
  logic               cfg_wr, cfg_sel_high;
  logic [ID_W-1:0]    low_new;
  status_t            st;

  assign range_empty = range_low_r > range_high_r;
  assign span  = {1'b0, range_high_r} - {1'b0, range_low_r} + FRESH_W'(1);
  assign cap_f = range_empty ? '0 : ((span < DEPTH_F) ? span : DEPTH_F);
  assign cap   = cap_f[CW-1:0];

  assign fresh_ok  = next_fresh_r <= {1'b0, range_high_r};
  assign ring_has  = (fill_r != '0) && (cap != '0);
  assign ring_room = fill_r < cap;

  assign head_inc  = {1'b0, head_r} + PW'(1);
  assign tail_inc  = {1'b0, tail_r} + PW'(1);
  assign head_wrap = (head_inc == PW'(cap)) ? '0 : head_inc[AW-1:0];
  assign tail_wrap = (tail_inc == PW'(cap)) ? '0 : tail_inc[AW-1:0];

  always_comb begin
    if (in_command == CMD_ALLOC) begin
      if (fresh_ok) begin
        st = ST_FRESH;
      end else if (ring_has) begin
        st = ST_REUSE;
      end else begin
        st = ST_NONE;
      end
    end else begin
      st = ring_room ? ST_STORED : ST_DROPPED;
    end
  end

  assign sts.reuse = (st == ST_REUSE);

  assign cfg_wr       = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel_high = (cfg_paddr[2] == REG_RANGE_HIGH);
  assign low_new      = cfg_sel_high ? range_low_r : cfg_pwdata[ID_W-1:0];
  assign cfg_prdata   = {(CFG_DATA_W - ID_W)'(0), cfg_sel_high ? range_high_r : range_low_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= RANGE_LOW_RST;
      range_high_r <= RANGE_HIGH_RST;
      next_fresh_r <= {1'b0, RANGE_LOW_RST};
      head_r       <= '0;
      tail_r       <= '0;
      fill_r       <= '0;
    end else if (cfg_wr) begin
      if (cfg_sel_high) begin
        range_high_r <= cfg_pwdata[ID_W-1:0];
      end else begin
        range_low_r <= cfg_pwdata[ID_W-1:0];
      end
      next_fresh_r <= {1'b0, low_new};
      head_r       <= '0;
      tail_r       <= '0;
      fill_r       <= '0;
    end else if (cmd.exec) begin
      case (st)
        ST_FRESH: begin
          next_fresh_r <= next_fresh_r + FRESH_W'(1);
        end
        ST_REUSE: begin
          head_r <= head_wrap;
          fill_r <= fill_r - CW'(1);
        end
        ST_STORED: begin
          tail_r <= tail_wrap;
          fill_r <= fill_r + CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && (st == ST_STORED)) begin
      ring_mem[tail_r] <= in_ident_in;
    end
    if (cmd.exec && (st == ST_REUSE)) begin
      rd_data_r <= ring_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status_r <= st;
      out_ident_r  <= (st == ST_FRESH) ? next_fresh_r[ID_W-1:0] : '0;
    end else if (cmd.load) begin
      out_ident_r <= rd_data_r;
    end
  end

  assign out_ident_out = out_ident_r;
  assign out_status    = out_status_r;

endmodule

`default_nettype wire

FILE: hdl/fresh_then_lru_id_allocator_top.sv
// ----------------------------------------------------------------------------
// fresh_then_lru_id_allocator_top
// A result is registered in the cycle after its command transfer; a reused
// grant first waits on the registered read port of the ring memory.
// Throughput: one command per cycle, stalled by out_stall or a reuse fetch.
// Reset: range 1024 to 2047, fresh counter at the low bound, ring empty; the
// ring memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module fresh_then_lru_id_allocator_top
  import ftla_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_command,
  input  wire logic [ID_W-1:0]       in_ident_in,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [ID_W-1:0]            out_ident_out,
  output logic [2:0]                 out_status,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  ftla_cmd_t cmd;
  ftla_sts_t sts;

  assign cfg_pready = 1'b1;

  ftla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ftla_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_command    (in_command),
    .in_ident_in   (in_ident_in),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .out_ident_out (out_ident_out),
    .out_status    (out_status)
  );

endmodule

`default_nettype wire

FILE: hdl/ftla_checker.sv
// ----------------------------------------------------------------------------
// ftla_checker
// Port-level checks on the allocator's transfers, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ftla_checker
  import ftla_pkg::*;
(
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_valid,
  input wire logic            in_stall,
  input wire logic            out_valid,
  input wire logic            out_stall,
  input wire logic [ID_W-1:0] out_ident_out,
  input wire logic [2:0]      out_status
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ident_out) && $stable(out_status))
    else $error("stalled result changed");

  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NONE || out_status == ST_STORED ||
                  out_status == ST_DROPPED) |-> out_ident_out == '0)
    else $error("identifier nonzero without a grant");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid || in_stall)
    else $error("accepted command neither finished nor blocking input");

endmodule

bind fresh_then_lru_id_allocator_top ftla_checker u_ftla_checker (.*);

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fresh-then-LRU identifier allocator. A
// directed table covers reset values, range extremes, empty ranges, a full
// ring and ring wrap. Random phases then reprogram the range and send
// allocate and release commands. A built-in allocator model predicts every
// result, and the result stream is compared in order. Both channels idle at
// random. Once the receiver holds off long enough to back up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import ftla_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = DEPTH_DEF;
  localparam int          RANDOM_ITEMS = 1200;

  typedef struct {
    logic [ID_W-1:0] ident;
    status_t         status;
  } grant_t;

  typedef struct packed {
    logic                  is_cfg;
    logic                  reg_idx;
    logic [CFG_DATA_W-1:0] value;
    logic                  cmd;
    logic [ID_W-1:0]       ident;
    logic                  typed;
    logic [ID_W-1:0]       x_ident;
    status_t               x_status;
  } script_row_t;

  localparam script_row_t SCRIPT [30] = '{
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_ALLOC,   16'h0000, 1'b1, 16'd1024, ST_FRESH},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_ALLOC,   16'h0000, 1'b1, 16'd1025, ST_FRESH},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_RELEASE, 16'hFFFF, 1'b1, 16'h0000, ST_STORED},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_RELEASE, 16'h0000, 1'b1, 16'h0000, ST_STORED},
    '{1'b1, REG_RANGE_LOW,  32'hABCD_0000, CMD_ALLOC,   16'h0000, 1'b0, 16'h0000, ST_NONE},
    '{1'b1, REG_RANGE_HIGH, 32'hFFFF_0000, CMD_ALLOC,   16'h0000, 1'b0, 16'h0000, ST_NONE},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_ALLOC,   16'h0000, 1'b1, 16'h0000, ST_FRESH},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_ALLOC,   16'h0000, 1'b1, 16'h0000, ST_NONE},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_RELEASE, 16'h5A5A, 1'b1, 16'h0000, ST_STORED},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_RELEASE, 16'hA5A5, 1'b1, 16'h0000, ST_DROPPED},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_ALLOC,   16'h0000, 1'b1, 16'h5A5A, ST_REUSE},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_ALLOC,   16'hFFFF, 1'b1, 16'h0000, ST_NONE},
    '{1'b1, REG_RANGE_LOW,  32'h0000_FFFF, CMD_ALLOC,   16'h0000, 1'b0, 16'h0000, ST_NONE},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_ALLOC,   16'h0000, 1'b1, 16'h0000, ST_NONE},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_RELEASE, 16'h1234, 1'b1, 16'h0000, ST_DROPPED},
    '{1'b1, REG_RANGE_HIGH, 32'h0000_FFFF, CMD_ALLOC,   16'h0000, 1'b0, 16'h0000, ST_NONE},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_ALLOC,   16'h0000, 1'b1, 16'hFFFF, ST_FRESH},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_ALLOC,   16'h0000, 1'b1, 16'h0000, ST_NONE},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_RELEASE, 16'h8001, 1'b1, 16'h0000, ST_STORED},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_ALLOC,   16'h0000, 1'b1, 16'h8001, ST_REUSE},
    '{1'b1, REG_RANGE_LOW,  32'h0000_FFFD, CMD_ALLOC,   16'h0000, 1'b0, 16'h0000, ST_NONE},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_RELEASE, 16'h0001, 1'b1, 16'h0000, ST_STORED},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_RELEASE, 16'h0002, 1'b1, 16'h0000, ST_STORED},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_RELEASE, 16'h0003, 1'b1, 16'h0000, ST_STORED},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_RELEASE, 16'h0004, 1'b1, 16'h0000, ST_DROPPED},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_ALLOC,   16'h0000, 1'b1, 16'hFFFD, ST_FRESH},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_ALLOC,   16'h0000, 1'b0, 16'h0000, ST_NONE},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_ALLOC,   16'h0000, 1'b0, 16'h0000, ST_NONE},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_ALLOC,   16'h0000, 1'b0, 16'h0000, ST_NONE},
    '{1'b0, REG_RANGE_LOW,  32'h0,         CMD_RELEASE, 16'h0005, 1'b0, 16'h0000, ST_NONE}
  };

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic                  in_command  = CMD_ALLOC;
  logic [ID_W-1:0]       in_ident_in = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [ID_W-1:0]       out_ident_out;
  logic [2:0]            out_status;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  fresh_then_lru_id_allocator_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_ident_in   (in_ident_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ident_out (out_ident_out),
    .out_status    (out_status),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  // Allocator model state.
  logic [ID_W-1:0]    lo_q = RANGE_LOW_RST;
  logic [ID_W-1:0]    hi_q = RANGE_HIGH_RST;
  logic [FRESH_W-1:0] fresh_next = {1'b0, RANGE_LOW_RST};
  logic [ID_W-1:0]    recycled [DEPTH];
  int unsigned        rd_pos = 0;
  int unsigned        wr_pos = 0;
  int unsigned        held = 0;

  grant_t grants_due [$];
  int     mismatches = 0;
  bit     steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic grant_t predict_grant(input logic cmd, input logic [ID_W-1:0] id);
    grant_t      g;
    int unsigned span;
    int unsigned cap;
    g.ident  = '0;
    g.status = ST_NONE;
    span = 32'(hi_q) - 32'(lo_q) + 1;
    cap  = (lo_q > hi_q) ? 0 : ((span < DEPTH) ? span : DEPTH);
    if (cmd == CMD_ALLOC) begin
      if (fresh_next <= {1'b0, hi_q}) begin
        g.ident    = fresh_next[ID_W-1:0];
        g.status   = ST_FRESH;
        fresh_next = fresh_next + 1'b1;
      end else if (held != 0 && cap != 0) begin
        g.ident  = recycled[rd_pos];
        g.status = ST_REUSE;
        rd_pos   = (rd_pos + 1) % cap;
        held--;
      end
    end else if (held < cap) begin
      recycled[wr_pos] = id;
      wr_pos   = (wr_pos + 1) % cap;
      held++;
      g.status = ST_STORED;
    end else begin
      g.status = ST_DROPPED;
    end
    return g;
  endfunction

  function automatic void flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endfunction

  // Called at a rising edge; returns at the edge where the transfer happens.
  task automatic send_cmd(input logic cmd, input logic [ID_W-1:0] id, input logic typed,
                          input logic [ID_W-1:0] x_ident, input status_t x_status);
    int     gap;
    grant_t g;
    gap = (!steady && $urandom_range(99) < 9) ? 1 : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_ident_in <= id;
    do @(posedge clk); while (in_stall);
    g = predict_grant(cmd, id);
    if (typed) begin
      g.ident  = x_ident;
      g.status = x_status;
    end
    grants_due.push_back(g);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (grants_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_range_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[ID_W-1:0] !== val[ID_W-1:0])
      flag_mismatch($sformatf("register %0d read back: expected %h, got %h",
                              idx, val[ID_W-1:0], cfg_prdata[ID_W-1:0]));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == REG_RANGE_LOW) lo_q = val[ID_W-1:0];
    else hi_q = val[ID_W-1:0];
    fresh_next = {1'b0, lo_q};
    rd_pos     = 0;
    wr_pos     = 0;
    held       = 0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_valid && !out_stall) begin
      if (grants_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected transfer: ident %h status %0d",
                                out_ident_out, out_status));
      end else begin
        g = grants_due.pop_front();
        if (out_ident_out !== g.ident || out_status !== g.status)
          flag_mismatch($sformatf("expected ident %h status %0d, got ident %h status %0d",
                                  g.ident, g.status, out_ident_out, out_status));
      end
    end
  end

  // Result side: random stalls, a quiet window, and one long hold-off.
  initial begin : receiver
    int got;
    bit held_off;
    got      = 0;
    held_off = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) got++;
      if (!held_off && got >= 600) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else begin
        out_stall <= (got >= 1000 && got < 1300) ? 1'b0 : ($urandom_range(99) < 9);
      end
    end
  end

  initial begin : stimulus
    int              sent;
    int              phase_len;
    int              span;
    int              rel_pct;
    int              pick;
    logic [ID_W-1:0] lo_pick;
    logic [ID_W-1:0] hi_pick;
    logic            cmd;
    logic [ID_W-1:0] id;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].is_cfg) begin
        settle();
        program_range_reg(SCRIPT[i].reg_idx, SCRIPT[i].value);
      end else begin
        send_cmd(SCRIPT[i].cmd, SCRIPT[i].ident, SCRIPT[i].typed,
                 SCRIPT[i].x_ident, SCRIPT[i].x_status);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent == 0) begin
        // Range wider than the ring, so the ring fills at its full depth.
        lo_pick   = 16'($urandom_range(64471, 0));
        hi_pick   = lo_pick + 16'(DEPTH) + 16'($urandom_range(40, 0));
        span      = 32'(hi_pick) - 32'(lo_pick) + 1;
        rel_pct   = 99;
        phase_len = 1040;
      end else begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          lo_pick = 16'($urandom_range(65535, 1));
          hi_pick = 16'($urandom_range(32'(lo_pick) - 1, 0));
          span    = 0;
        end else begin
          span    = (pick < 30) ? $urandom_range(300, 17) : $urandom_range(16, 1);
          lo_pick = 16'($urandom_range(65536 - span, 0));
          if (pick % 10 == 0) lo_pick = '0;
          else if (pick % 10 == 1) lo_pick = 16'(65536 - span);
          hi_pick = lo_pick + 16'(span - 1);
        end
        rel_pct   = $urandom_range(65, 25);
        phase_len = $urandom_range(90, 30);
      end
      settle();
      if ($urandom_range(1)) begin
        program_range_reg(REG_RANGE_LOW, {16'($urandom), lo_pick});
        program_range_reg(REG_RANGE_HIGH, {16'($urandom), hi_pick});
      end else begin
        program_range_reg(REG_RANGE_HIGH, {16'($urandom), hi_pick});
        program_range_reg(REG_RANGE_LOW, {16'($urandom), lo_pick});
      end
      for (int k = 0; k < phase_len; k++) begin
        if (sent == 1170) settle();
        steady = (sent >= 1000 && sent < 1150);
        cmd = ($urandom_range(99) < rel_pct) ? CMD_RELEASE : CMD_ALLOC;
        id  = ($urandom_range(3) == 0) ? lo_pick + 16'($urandom_range(7)) : 16'($urandom);
        send_cmd(cmd, id, 1'b0, '0, ST_NONE);
        sent++;
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && grants_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
